// ===== design/sliding_window_maximum_assert.svh =====
// ----------------------------------------------------------------------------
// sliding_window_maximum_assert.svh
// Assertion macros used by the sliding window maximum design file.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MAXIMUM_ASSERT_SVH
`define SLIDING_WINDOW_MAXIMUM_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SWM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// Constants and types of the sliding window maximum block.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int PTR_W       = $clog2(WINDOW_MAX);
  localparam int CNT_W       = PTR_W + 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [PTR_W-1:0]              ptr_t;
  typedef logic [CNT_W-1:0]              cnt_t;

  // Per-item sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RETIRE,
    ST_POP_RD,
    ST_POP_CMP,
    ST_PUSH,
    ST_OUT
  } state_t;

endpackage

// ===== design/sliding_window_maximum.sv =====
// Sequence: an item is accepted in ST_IDLE; on a full window ST_RETIRE checks the head
//   against the leaving sample; ST_POP_RD/ST_POP_CMP compare tail entries; ST_PUSH, ST_OUT.
// One item at a time: the next item is taken only after the result is loaded into the
//   output register, which can stall on m_tready, or after the push if there is none.
// Reset: synchronous, sets the window size to 4 and empties the deque;
//   memory contents are left as they are and never read before written.
// ----------------------------------------------------------------------------
// sliding_window_maximum
// Running maximum over the last window_size samples, kept as a monotonic
// deque in one memory and a delay line of recent samples in another.
// ----------------------------------------------------------------------------
module sliding_window_maximum (
  input  logic                          clk,
  input  logic                          rst,
  // Config write channel: window_size
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [swm_pkg::CNT_W-1:0]     cfg_data,
  // Input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [swm_pkg::SAMPLE_BITS-1:0] s_tdata,  // [31:0] sample
  input  logic                          s_tlast,   // last_sample
  // Output stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [swm_pkg::SAMPLE_BITS-1:0] m_tdata   // [31:0] window_max
);
  import swm_pkg::*;

  `include "sliding_window_maximum_assert.svh"

  // Registers
  state_t  state, state_next;
  cnt_t    window_size, window_size_next;
  ptr_t    cand_head, cand_head_next;
  cnt_t    cand_count, cand_count_next;
  ptr_t    rec_ptr, rec_ptr_next;
  cnt_t    samples_seen, samples_seen_next;
  sample_t samp;
  logic    last_q;
  logic    head_fwd, head_fwd_next;

  // Memories and their ports
  sample_t cand_mem [WINDOW_MAX];
  sample_t rec_mem  [WINDOW_MAX];
  sample_t cand_q, rec_q;
  logic    cand_re, cand_we, rec_re, rec_we;
  ptr_t    cand_ra, cand_wa, rec_ra;

  // Control
  cnt_t    w_eff;
  ptr_t    tail_idx, old_idx, head_p;
  cnt_t    count_p, seen_n;
  logic    samp_load, out_load, clear;

  // Effective window: zero acts as one, large values saturate
  always_comb begin
    if (window_size == '0) begin
      w_eff = CNT_W'(1);
    end else if (window_size > CNT_W'(WINDOW_MAX)) begin
      w_eff = CNT_W'(WINDOW_MAX);
    end else begin
      w_eff = window_size;
    end
  end

  assign tail_idx = cand_head + cand_count[PTR_W-1:0] - PTR_W'(1);
  assign old_idx  = rec_ptr - w_eff[PTR_W-1:0];

  // Sequencer: next state and memory controls
  always_comb begin
    state_next        = state;
    window_size_next  = window_size;
    cand_head_next    = cand_head;
    cand_count_next   = cand_count;
    rec_ptr_next      = rec_ptr;
    samples_seen_next = samples_seen;
    head_fwd_next     = head_fwd;
    cand_re   = 1'b0;
    cand_ra   = '0;
    cand_we   = 1'b0;
    cand_wa   = '0;
    rec_re    = 1'b0;
    rec_ra    = '0;
    rec_we    = 1'b0;
    samp_load = 1'b0;
    out_load  = 1'b0;
    clear     = 1'b0;
    s_tready  = 1'b0;
    cfg_ready = 1'b0;
    head_p    = cand_head;
    count_p   = cand_count;
    seen_n    = samples_seen;

    case (state)
      ST_IDLE: begin
        cfg_ready = 1'b1;
        s_tready  = !cfg_valid;
        if (cfg_valid) begin
          window_size_next = cfg_data;
          clear            = 1'b1;
        end else if (s_tvalid) begin
          samp_load = 1'b1;
          if (samples_seen >= w_eff) begin
            // fetch deque head and the sample leaving the window
            cand_re    = 1'b1;
            cand_ra    = cand_head;
            rec_re     = 1'b1;
            rec_ra     = old_idx;
            state_next = ST_RETIRE;
          end else begin
            state_next = ST_POP_RD;
          end
        end
      end

      ST_RETIRE: begin
        if (cand_count != '0 && cand_q == rec_q) begin
          cand_head_next  = cand_head + PTR_W'(1);
          cand_count_next = cand_count - CNT_W'(1);
        end
        state_next = ST_POP_RD;
      end

      ST_POP_RD: begin
        if (cand_count == '0) begin
          state_next = ST_PUSH;
        end else begin
          cand_re    = 1'b1;
          cand_ra    = tail_idx;
          state_next = ST_POP_CMP;
        end
      end

      ST_POP_CMP: begin
        // drop tail values strictly smaller than the new sample
        if (cand_q < samp) begin
          cand_count_next = cand_count - CNT_W'(1);
          state_next      = ST_POP_RD;
        end else begin
          state_next = ST_PUSH;
        end
      end

      ST_PUSH: begin
        if (cand_count == CNT_W'(WINDOW_MAX)) begin
          head_p  = cand_head + PTR_W'(1);
          count_p = cand_count - CNT_W'(1);
        end
        cand_we         = 1'b1;
        cand_wa         = head_p + count_p[PTR_W-1:0];
        cand_head_next  = head_p;
        cand_count_next = count_p + CNT_W'(1);
        rec_we          = 1'b1;
        rec_ptr_next    = rec_ptr + PTR_W'(1);
        seen_n          = (samples_seen < w_eff) ? samples_seen + CNT_W'(1) : samples_seen;
        samples_seen_next = seen_n;
        if (seen_n >= w_eff) begin
          // head read; an empty deque means the head is this sample
          cand_re       = 1'b1;
          cand_ra       = head_p;
          head_fwd_next = (count_p == '0);
          state_next    = ST_OUT;
        end else begin
          clear      = last_q;
          state_next = ST_IDLE;
        end
      end

      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          clear      = last_q;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // end of sequence or new window size
    if (clear) begin
      cand_head_next    = '0;
      cand_count_next   = '0;
      rec_ptr_next      = '0;
      samples_seen_next = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      window_size  <= CNT_W'(4);
      cand_head    <= '0;
      cand_count   <= '0;
      rec_ptr      <= '0;
      samples_seen <= '0;
      head_fwd     <= 1'b0;
    end else begin
      state        <= state_next;
      window_size  <= window_size_next;
      cand_head    <= cand_head_next;
      cand_count   <= cand_count_next;
      rec_ptr      <= rec_ptr_next;
      samples_seen <= samples_seen_next;
      head_fwd     <= head_fwd_next;
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (samp_load) begin
      samp   <= sample_t'(s_tdata);
      last_q <= s_tlast;
    end
  end

  // Candidate deque memory
  always_ff @(posedge clk) begin
    if (cand_we) begin
      cand_mem[cand_wa] <= samp;
    end
    if (cand_re) begin
      cand_q <= cand_mem[cand_ra];
    end
  end

  // Recent sample delay line memory
  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rec_ptr] <= samp;
    end
    if (rec_re) begin
      rec_q <= rec_mem[rec_ra];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= head_fwd ? samp : cand_q;
    end
  end

  // Checks
  `SWM_ASSERT_NOW(a_count_le_seen, 1'b1, cand_count <= samples_seen,
                  "deque holds more entries than samples seen")
  `SWM_ASSERT_NOW(a_pop_nonempty, state == ST_POP_CMP, cand_count != '0,
                  "tail compare on an empty deque")
  `SWM_ASSERT_NOW(a_push_room, state == ST_PUSH, cand_count < w_eff,
                  "deque full at push")
  `SWM_ASSERT_NOW(a_out_full, state == ST_OUT, samples_seen >= w_eff,
                  "result from a window that is not full")
  `SWM_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready,
                   "second item taken while one is in work")

endmodule

// ===== sim/sliding_window_maximum_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_maximum_tb
// Self-checking bench for the sliding window maximum block. Samples stream in
// through bursts with random gaps while the output side stalls on its own
// pattern. A local deque tracker predicts every window maximum, and each
// result item is compared against the oldest prediction. Window sizes are
// changed only while the block is idle, and include the out-of-range values
// that the block clamps.
// ----------------------------------------------------------------------------
module sliding_window_maximum_tb;
  import swm_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int SETTLE_CYCLES  = 4 + 2 * WINDOW_MAX + 1 + 16;
  localparam int DRAIN_LIMIT    = 200000;
  localparam int HOLD_CYCLES    = 2000;
  localparam int RANDOM_ITEMS   = 1500;
  localparam longint RUN_LIMIT_NS = 64'd24_000_000;

  // Content shapes for generated sequences
  typedef enum int {
    SHAPE_RANDOM,
    SHAPE_NARROW,
    SHAPE_RISING,
    SHAPE_FALLING,
    SHAPE_EXTREME
  } shape_t;

  // Receiver stall patterns
  typedef enum int {
    RX_STEADY,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  logic    clk;
  logic    rst       = 1'b1;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  cnt_t    cfg_data  = '0;
  logic    s_tvalid  = 1'b0;
  logic    s_tready;
  logic [SAMPLE_BITS-1:0] s_tdata = '0;  // [31:0] sample
  logic    s_tlast   = 1'b0;             // last_sample
  logic    m_tvalid;
  logic    m_tready  = 1'b0;
  logic [SAMPLE_BITS-1:0] m_tdata;       // [31:0] window_max

  // Predictor state
  cnt_t    window_size;
  sample_t window_hist[$];
  sample_t candidates[$];
  sample_t pending_max[$];

  // Bookkeeping
  int      mismatches     = 0;
  int      items_sent     = 0;
  int      maxima_checked = 0;
  int      settings_used  = 0;
  int      burst_left     = 0;
  int      hold_request   = 0;

  sliding_window_maximum dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // Run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

  // Window size after clamping
  function automatic int unsigned window_span(cnt_t w);
    if (w == 0) return 1;
    if (w > WINDOW_MAX) return WINDOW_MAX;
    return 32'(w);
  endfunction

  // Monotonic deque tracker: one accepted sample in, at most one maximum out
  function automatic void track_sample(sample_t s, bit last);
    int unsigned w;
    sample_t     leaving;
    w = window_span(window_size);
    // retire the sample leaving the window
    if (window_hist.size() >= w) begin
      leaving = window_hist[0];
      window_hist.delete(0);
      if (candidates.size() > 0 && candidates[0] == leaving) candidates.delete(0);
    end
    // drop smaller tail candidates, keep equal ones
    while (candidates.size() > 0 && candidates[$] < s) candidates.delete(candidates.size() - 1);
    candidates.insert(candidates.size(), s);
    window_hist.insert(window_hist.size(), s);
    if (window_hist.size() >= w) pending_max.insert(pending_max.size(), candidates[0]);
    if (last) begin
      candidates.delete();
      window_hist.delete();
    end
  endfunction

  // Result check first, then register writes, then input prediction
  always @(posedge clk) begin
    if (rst) begin
      window_size = 7'd4;
      candidates.delete();
      window_hist.delete();
      pending_max.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_max.size() == 0) begin
          $error("window_max: result with no expectation, actual %0d", sample_t'(m_tdata));
          mismatches++;
        end else begin
          sample_t want;
          want = pending_max[0];
          pending_max.delete(0);
          if (sample_t'(m_tdata) !== want) begin
            $error("window_max: expected %0d, actual %0d", want, sample_t'(m_tdata));
            mismatches++;
          end
          maxima_checked++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        window_size = cfg_data;
        candidates.delete();
        window_hist.delete();
      end
      if (s_tvalid && s_tready) track_sample(sample_t'(s_tdata), s_tlast);
    end
  end

  // Output side stalls: random patterns of random length, long holds on request
  rx_mode_t rx_mode  = RX_STEADY;
  int       rx_left  = 0;
  int       rx_phase = 0;
  int       hold_left = 0;
  int       holds_served = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_request != holds_served) begin
        hold_left    = HOLD_CYCLES;
        holds_served = hold_request;
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 200);
      end else begin
        rx_left--;
      end
      rx_phase++;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_STEADY:   m_tready <= 1'b1;
          RX_LIGHT:    m_tready <= ($urandom_range(0, 7) != 0);
          RX_HEAVY:    m_tready <= ($urandom_range(0, 1) == 1);
          default:     m_tready <= (rx_phase % 3 == 0);
        endcase
      end
    end
  end

  // Send one item; the sender works in bursts with random gaps between them
  task automatic send_item(sample_t v, bit last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tdata  <= v;
    s_tlast  <= last;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Stop sending and wait until every predicted maximum has come
  task automatic pause_sender();
    int n;
    n = 0;
    s_tvalid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_max.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    // an item with no result may still be in work
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(cnt_t w);
    pause_sender();
    cfg_data  <= w;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic sample_t make_sample(shape_t shape, int i);
    case (shape)
      SHAPE_NARROW:  return sample_t'($urandom_range(0, 6)) - 3;
      SHAPE_RISING:  return sample_t'(i * 16 + $urandom_range(0, 15)) - 5000;
      SHAPE_FALLING: return 1000000 - sample_t'(i * 16 + $urandom_range(0, 15));
      SHAPE_EXTREME: begin
        case ($urandom_range(0, 5))
          0:       return sample_t'(32'h8000_0000);
          1:       return sample_t'(32'h7FFF_FFFF);
          2:       return sample_t'(32'h8000_0001);
          3:       return sample_t'(32'h7FFF_FFFE);
          4:       return '0;
          default: return '1;
        endcase
      end
      default:       return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_sequence(int n, shape_t shape, bit close);
    for (int i = 0; i < n; i++) send_item(make_sample(shape, i), close && (i == n - 1));
  endtask

  // Reset window of four: extremes, equal values, last on a filling and a full window
  task automatic test_directed();
    // last sample before the window fills: no result, state cleared
    send_item(5, 1'b0);
    send_item(-3, 1'b0);
    send_item(7, 1'b1);
    send_item(sample_t'(32'h8000_0000), 1'b0);
    send_item(sample_t'(32'h7FFF_FFFF), 1'b0);
    send_item(0, 1'b0);
    send_item(-1, 1'b0);
    send_item(sample_t'(32'h5555_5555), 1'b0);
    send_item(sample_t'(32'hAAAA_AAAA), 1'b0);
    // equal values stay in the deque
    send_item(-1, 1'b0);
    send_item(-1, 1'b0);
    send_item(-1, 1'b0);
    send_item(3, 1'b0);
    send_item(3, 1'b0);
    // falling run fills the deque, then head retires
    send_item(2, 1'b0);
    send_item(1, 1'b0);
    send_item(0, 1'b0);
    send_item(-5, 1'b0);
    send_item(sample_t'(32'h8000_0000), 1'b0);
    send_item(sample_t'(32'h8000_0000), 1'b1);
    send_item(sample_t'(32'h7FFF_FFFF), 1'b0);
  endtask

  // Clamped and boundary window sizes
  task automatic test_window_sizes();
    write_window(7'd0);
    send_sequence(12, SHAPE_EXTREME, 1'b1);
    write_window(7'd1);
    send_sequence(12, SHAPE_NARROW, 1'b1);
    write_window(7'd2);
    send_sequence(12, SHAPE_RANDOM, 1'b1);
    write_window(7'd64);
    send_sequence(70, SHAPE_FALLING, 1'b0);
    send_sequence(30, SHAPE_RANDOM, 1'b1);
    write_window(7'd127);
    send_sequence(70, SHAPE_NARROW, 1'b1);
    write_window(7'd65);
    send_sequence(70, SHAPE_RISING, 1'b1);
    write_window(7'd3);
    send_sequence(15, SHAPE_RANDOM, 1'b0);
  endtask

  // Long receiver hold while the sender keeps offering, then a full drain
  task automatic test_backpressure();
    write_window(7'd2);
    hold_request++;
    send_sequence(40, SHAPE_RANDOM, 1'b0);
    pause_sender();
    send_sequence(10, SHAPE_NARROW, 1'b1);
  endtask

  // Random sequences, mostly well formed, some cut short or left open
  task automatic test_random();
    int     sent;
    int     since_cfg;
    int     w;
    int     len;
    int     pick;
    shape_t shape;
    sent      = 0;
    since_cfg = 0;
    w         = 3;
    while (sent < RANDOM_ITEMS) begin
      if (since_cfg == 0 || since_cfg > 250) begin
        pick = $urandom_range(0, 9);
        if (pick < 7)       w = $urandom_range(1, 8);
        else if (pick < 9)  w = $urandom_range(9, 20);
        else begin
          case ($urandom_range(0, 3))
            0:       w = 0;
            1:       w = 32;
            2:       w = 64;
            default: w = 100;
          endcase
        end
        write_window(cnt_t'(w));
        since_cfg = 1;
      end
      shape = shape_t'($urandom_range(0, 4));
      if ($urandom_range(0, 7) == 0) len = $urandom_range(1, window_span(cnt_t'(w)));
      else len = window_span(cnt_t'(w)) + $urandom_range(0, 2 * window_span(cnt_t'(w)) + 10);
      send_sequence(len, shape, $urandom_range(0, 7) != 0);
      sent      += len;
      since_cfg += len;
    end
  endtask

  // Test sequence
  initial begin
    @(negedge rst);
    @(posedge clk);
    test_directed();
    test_window_sizes();
    test_backpressure();
    test_random();
    pause_sender();
    if (pending_max.size() != 0) begin
      $error("window_max: %0d expected results never came", pending_max.size());
      mismatches++;
    end
    $display("Run covered %0d items over %0d window settings; %0d window maxima compared.",
             items_sent, settings_used, maxima_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
